FILE: rtl/dhws_pkg.sv
// dhws_pkg: shared widths, operation codes, sequencer states and
// saturation helpers for the damped heightfield wave sweep block.
// No dependencies.
package dhws_pkg;

   // field widths
   localparam int DATA_W   = 24;
   localparam int FUNC_W   = 2;
   localparam int COLUMN_W = 7;
   localparam int ROW_W    = 6;
   localparam int DAMP_W   = 16;

   // default grid resolution and damping reset value
   localparam int GRID_RES_DEFAULT = 64;
   localparam logic [DAMP_W-1:0] DAMP_RESET = 16'd64880;

   // cell update arithmetic: t in 2^-22 units, product in 2^-38 units
   localparam int T_W       = 28;
   localparam int P_W       = T_W + DAMP_W + 1;
   localparam int RND_SHIFT = 18;
   localparam int Q_W       = P_W - RND_SHIFT;

   localparam logic signed [DATA_W-1:0] Q_MAX = 24'sh7FFFFF;
   localparam logic signed [DATA_W-1:0] Q_MIN = 24'sh800000;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd2;

   // sequencer states
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CLEAR = 7'b0000010,
      ST_WRITE = 7'b0000100,
      ST_READ  = 7'b0001000,
      ST_RDATA = 7'b0010000,
      ST_SWEEP = 7'b0100000,
      ST_DRAIN = 7'b1000000
   } state_type;

   // saturate the rounded, shifted product to a 24-bit velocity
   function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [Q_W-1:0] x);
      logic signed [DATA_W-1:0] r;
      if (x > Q_W'(Q_MAX)) begin
         r = Q_MAX;
      end else if (x < Q_W'(Q_MIN)) begin
         r = Q_MIN;
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

   // saturate a height plus velocity sum to 24 bits
   function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [DATA_W:0] x);
      logic signed [DATA_W-1:0] r;
      if (x > (DATA_W+1)'(Q_MAX)) begin
         r = Q_MAX;
      end else if (x < (DATA_W+1)'(Q_MIN)) begin
         r = Q_MIN;
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/damped_heightfield_wave_sweep.sv
// damped_heightfield_wave_sweep: height and velocity grids in two memories,
// cell write/read and an in-place damped relaxation sweep. Uses dhws_pkg.
// A write is answered from the write state, a read after the read and read-data
// states, and a step after the cell sweep and drain; a new request is taken only
// in idle, once busy has fallen. Each cell passes two read phases, a sum and a
// damping product, with rounding and write-back overlapped into the next cell.
// Reset clears both grids in a pass over every cell while busy stays high;
// the results are strobed for one cycle and cannot stall.
module damped_heightfield_wave_sweep #(
   parameter int GRID_RES = dhws_pkg::GRID_RES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic [dhws_pkg::FUNC_W-1:0]         req_func,
   input  logic [dhws_pkg::COLUMN_W-1:0]       req_column,
   input  logic [dhws_pkg::ROW_W-1:0]          req_row,
   input  logic signed [dhws_pkg::DATA_W-1:0]  req_height_in,
   // result channel
   output logic                                rsp_valid,
   output logic signed [dhws_pkg::DATA_W-1:0]  rsp_height_out,
   output logic signed [dhws_pkg::DATA_W-1:0]  rsp_velocity_out,
   output logic [dhws_pkg::FUNC_W-1:0]         rsp_op_done,
   // damping register
   input  logic                                csr_write_en,
   input  logic [dhws_pkg::DAMP_W-1:0]         csr_write_data
);
   import dhws_pkg::*;

   localparam int COLS  = GRID_RES + 1;
   localparam int CELLS = COLS * GRID_RES;
   localparam int CW    = $clog2(COLS);
   localparam int RW    = $clog2(GRID_RES);
   localparam int AW    = $clog2(CELLS);

   // grid memories
   logic signed [DATA_W-1:0] height_mem [CELLS];
   logic signed [DATA_W-1:0] velocity_mem [CELLS];

   logic                     h_we, v_we;
   logic [AW-1:0]            h_waddr, v_waddr, h_raddr_a, h_raddr_b, v_raddr;
   logic signed [DATA_W-1:0] h_wdata, v_wdata;
   logic signed [DATA_W-1:0] h_rd_a_ff, h_rd_b_ff, v_rd_ff;

   // control registers
   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_idx_ff, clr_idx_in;
   logic [1:0]        phase_ff, phase_in;
   logic              rnd_go_ff, rnd_go_in;
   logic              wr_go_ff, wr_go_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DAMP_W-1:0] damp_ff, damp_in;

   // sweep position and request payload
   logic [CW-1:0]            col_ff, col_in;
   logic [RW-1:0]            row_ff, row_in;
   logic [AW-1:0]            idx_ff, idx_in;
   logic [AW-1:0]            op_idx_ff, op_idx_in;
   logic signed [DATA_W-1:0] op_h_ff, op_h_in;

   // cell pipeline
   logic signed [DATA_W-1:0] center_ff, center_in;
   logic signed [DATA_W-1:0] east_ff, east_in;
   logic signed [DATA_W-1:0] vel_ff, vel_in;
   logic signed [DATA_W-1:0] west_ff, west_in;
   logic signed [T_W-1:0]    t_ff, t_in;
   logic signed [P_W-1:0]    prod_ff, prod_in;
   logic signed [DATA_W-1:0] hold_h_ff, hold_h_in;
   logic [AW-1:0]            wr_idx_ff, wr_idx_in;
   logic signed [DATA_W-1:0] vnew_ff, vnew_in;

   // result registers
   logic signed [DATA_W-1:0] rsp_h_ff, rsp_h_in;
   logic signed [DATA_W-1:0] rsp_v_ff, rsp_v_in;
   logic [FUNC_W-1:0]        rsp_op_ff, rsp_op_in;

   // combinational helpers
   logic [CW-1:0]            col_c;
   logic [RW-1:0]            row_c;
   logic [AW-1:0]            east_idx, south_idx, north_idx;
   logic signed [DATA_W-1:0] west_val;
   logic signed [DAMP_W:0]   damp_s;
   logic signed [P_W-1:0]    rnd_add, rnd_sum;
   logic signed [Q_W-1:0]    rnd_q;
   logic signed [DATA_W:0]   h_sum;
   logic signed [DATA_W-1:0] h_new;

   // request index clamp
   assign col_c = (32'(req_column) > GRID_RES) ? CW'(GRID_RES) : CW'(req_column);
   assign row_c = (32'(req_row) > GRID_RES - 1) ? RW'(GRID_RES - 1) : RW'(req_row);

   // neighbour addresses with edge clamping
   assign east_idx  = (col_ff == CW'(GRID_RES)) ? idx_ff : idx_ff + AW'(1);
   assign south_idx = (row_ff == '0) ? idx_ff : idx_ff - AW'(COLS);
   assign north_idx = (row_ff == RW'(GRID_RES - 1)) ? idx_ff : idx_ff + AW'(COLS);
   assign west_val  = (col_ff == '0) ? center_ff : west_ff;

   // round half away from zero, then shift
   assign damp_s  = $signed({1'b0, damp_ff});
   assign rnd_add = prod_ff[P_W-1] ? P_W'((1 << (RND_SHIFT - 1)) - 1)
                                   : P_W'(1 << (RND_SHIFT - 1));
   assign rnd_sum = prod_ff + rnd_add;
   assign rnd_q   = rnd_sum[P_W-1:RND_SHIFT];

   // new height from held height and new velocity
   assign h_sum = (DATA_W+1)'(hold_h_ff) + (DATA_W+1)'(vnew_ff);
   assign h_new = sat_sum(h_sum);

   // next-state and memory port logic
   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      phase_in     = phase_ff;
      rnd_go_in    = 1'b0;
      wr_go_in     = rnd_go_ff;
      rsp_valid_in = 1'b0;
      damp_in      = damp_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      idx_in       = idx_ff;
      op_idx_in    = op_idx_ff;
      op_h_in      = op_h_ff;
      center_in    = center_ff;
      east_in      = east_ff;
      vel_in       = vel_ff;
      west_in      = west_ff;
      t_in         = t_ff;
      prod_in      = prod_ff;
      hold_h_in    = hold_h_ff;
      wr_idx_in    = wr_idx_ff;
      vnew_in      = vnew_ff;
      rsp_h_in     = rsp_h_ff;
      rsp_v_in     = rsp_v_ff;
      rsp_op_in    = rsp_op_ff;

      h_we      = 1'b0;
      h_waddr   = wr_idx_ff;
      h_wdata   = h_new;
      v_we      = 1'b0;
      v_waddr   = wr_idx_ff;
      v_wdata   = vnew_ff;
      h_raddr_a = idx_ff;
      h_raddr_b = idx_ff;
      v_raddr   = idx_ff;

      // damping register write
      if (csr_write_en) begin
         damp_in = csr_write_data;
      end

      // round and saturate stage
      if (rnd_go_ff) begin
         vnew_in = sat_q(rnd_q);
      end

      // write-back stage, forwards the new height as the next west value
      if (wr_go_ff) begin
         h_we    = 1'b1;
         v_we    = 1'b1;
         west_in = h_new;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            h_we    = 1'b1;
            h_waddr = clr_idx_ff;
            h_wdata = '0;
            v_we    = 1'b1;
            v_waddr = clr_idx_ff;
            v_wdata = '0;
            if (clr_idx_ff == AW'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_idx_in = AW'(AW'(row_c) * AW'(COLS)) + AW'(col_c);
               op_h_in   = req_height_in;
               rsp_op_in = req_func;
               unique case (req_func)
                  FUNC_WRITE: state_in = ST_WRITE;
                  FUNC_READ:  state_in = ST_READ;
                  FUNC_STEP: begin
                     state_in = ST_SWEEP;
                     col_in   = '0;
                     row_in   = '0;
                     idx_in   = '0;
                     phase_in = '0;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_WRITE: begin
            h_we         = 1'b1;
            h_waddr      = op_idx_ff;
            h_wdata      = op_h_ff;
            v_we         = 1'b1;
            v_waddr      = op_idx_ff;
            v_wdata      = '0;
            rsp_h_in     = '0;
            rsp_v_in     = '0;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_READ: begin
            h_raddr_a = op_idx_ff;
            v_raddr   = op_idx_ff;
            state_in  = ST_RDATA;
         end
         ST_RDATA: begin
            rsp_h_in     = h_rd_a_ff;
            rsp_v_in     = v_rd_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SWEEP: begin
            phase_in = phase_ff + 2'd1;
            unique case (phase_ff)
               // read center, east and velocity
               2'd0: begin
                  h_raddr_a = idx_ff;
                  h_raddr_b = east_idx;
                  v_raddr   = idx_ff;
               end
               // capture them, read south and north
               2'd1: begin
                  center_in = h_rd_a_ff;
                  east_in   = h_rd_b_ff;
                  vel_in    = v_rd_ff;
                  h_raddr_a = south_idx;
                  h_raddr_b = north_idx;
               end
               // t = 4v + neighbours - 4h
               2'd2: begin
                  t_in = (T_W'(vel_ff) <<< 2) + T_W'(east_ff) + T_W'(west_val)
                       + T_W'(h_rd_a_ff) + T_W'(h_rd_b_ff) - (T_W'(center_ff) <<< 2);
               end
               // damping product, hand the cell to the round stage, advance
               default: begin
                  prod_in   = t_ff * damp_s;
                  hold_h_in = center_ff;
                  wr_idx_in = idx_ff;
                  rnd_go_in = 1'b1;
                  if (idx_ff == AW'(CELLS - 1)) begin
                     state_in = ST_DRAIN;
                  end else begin
                     idx_in = idx_ff + AW'(1);
                     if (col_ff == CW'(GRID_RES)) begin
                        col_in = '0;
                        row_in = row_ff + RW'(1);
                     end else begin
                        col_in = col_ff + CW'(1);
                     end
                  end
               end
            endcase
         end
         ST_DRAIN: begin
            if (wr_go_ff) begin
               rsp_h_in     = '0;
               rsp_v_in     = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         phase_ff     <= '0;
         rnd_go_ff    <= 1'b0;
         wr_go_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         damp_ff      <= DAMP_RESET;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         phase_ff     <= phase_in;
         rnd_go_ff    <= rnd_go_in;
         wr_go_ff     <= wr_go_in;
         rsp_valid_ff <= rsp_valid_in;
         damp_ff      <= damp_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      col_ff    <= col_in;
      row_ff    <= row_in;
      idx_ff    <= idx_in;
      op_idx_ff <= op_idx_in;
      op_h_ff   <= op_h_in;
      center_ff <= center_in;
      east_ff   <= east_in;
      vel_ff    <= vel_in;
      west_ff   <= west_in;
      t_ff      <= t_in;
      prod_ff   <= prod_in;
      hold_h_ff <= hold_h_in;
      wr_idx_ff <= wr_idx_in;
      vnew_ff   <= vnew_in;
      rsp_h_ff  <= rsp_h_in;
      rsp_v_ff  <= rsp_v_in;
      rsp_op_ff <= rsp_op_in;
   end

   // height memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (h_we) begin
         height_mem[h_waddr] <= h_wdata;
      end
      h_rd_a_ff <= height_mem[h_raddr_a];
      h_rd_b_ff <= height_mem[h_raddr_b];
   end

   // velocity memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (v_we) begin
         velocity_mem[v_waddr] <= v_wdata;
      end
      v_rd_ff <= velocity_mem[v_raddr];
   end

   // outputs
   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_height_out   = rsp_h_ff;
   assign rsp_velocity_out = rsp_v_ff;
   assign rsp_op_done      = rsp_op_ff;

   // write-back lands only in the second phase of the next cell or in drain
   a_wb_slot: assert property (@(posedge clock) disable iff (reset)
      wr_go_ff |-> ((state_ff == ST_SWEEP && phase_ff == 2'd1) || state_ff == ST_DRAIN))
      else $error("sweep write-back out of its slot");

   // a write-back never hits an entry that is being read in the same cycle
   a_wb_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (wr_go_ff && state_ff == ST_SWEEP) |->
         (h_raddr_a != wr_idx_ff && h_raddr_b != wr_idx_ff && v_raddr != wr_idx_ff))
      else $error("sweep read overlaps pending write-back");

   // a step result only after the cell pipeline has drained
   a_step_drained: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_op_ff == FUNC_STEP) |-> (!rnd_go_ff && !wr_go_ff))
      else $error("step result with cells still in flight");

   // clearing pass stays inside the grid
   a_clear_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (32'(clr_idx_ff) < CELLS))
      else $error("clear index beyond grid");

   // results are never strobed in two consecutive cycles
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("back-to-back result strobes");

endmodule
